/* sv/mtnc_pkg.sv */
// Shared types and type codes of the mixed-type number compare unit.
package mtnc_pkg;

    // Operand type codes
    localparam logic [3:0] TY_I8  = 4'd0;
    localparam logic [3:0] TY_U8  = 4'd1;
    localparam logic [3:0] TY_I16 = 4'd2;
    localparam logic [3:0] TY_U16 = 4'd3;
    localparam logic [3:0] TY_I32 = 4'd4;
    localparam logic [3:0] TY_U32 = 4'd5;
    localparam logic [3:0] TY_I64 = 4'd6;
    localparam logic [3:0] TY_U64 = 4'd7;
    localparam logic [3:0] TY_SGL = 4'd8;
    localparam logic [3:0] TY_DBL = 4'd9;

    // Exponent given to infinities, above any finite value
    localparam logic signed [12:0] INF_EXP = 13'sd2000;

    // One operand in sign / magnitude form: value = mag * 2^off before
    // normalization, mant * 2^(exp-63) after it.
    typedef struct packed {
        logic               sign;
        logic               zero;
        logic               nan;
        logic               inf;
        logic [63:0]        mag;
        logic signed [12:0] off;
        logic [63:0]        pat;   // double bit pattern, used for NaNs only
    } mtnc_op_t;

    // Per-beat control that rides with the operands
    typedef struct packed {
        logic invalid;
        logic both_float;
        logic nan_mode;
        logic rnd_a;
        logic rnd_b;
    } mtnc_ctl_t;

endpackage

/* sv/mixed_type_number_compare_unit.sv */
// Top level of the mixed-type number compare unit.
// Compares two tagged numbers (int8..uint64, single, double) and returns a
// less-than and an equal flag. One beat is accepted every cycle while the
// output is not stalled; each result is registered through the pipeline stages
// (decode, leading-zero count, normalize, round, compare). Mixed pairs that
// include a 64-bit integer are compared after rounding it to double, except
// the pairs among int64, uint64 and double, which are compared exactly.
// Back pressure on the output stalls the whole pipeline.
module mixed_type_number_compare_unit
    import mtnc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_bits[63:0], a_type[67:64], b_bits[131:68], b_type[135:132],
    // nan_equal_mode[136], zero fill
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // less_than[0], equal_flag[1], zero fill
    output logic [7:0]   m_tdata
);

    // Decode raw bits into sign / magnitude / offset form
    function automatic mtnc_op_t decode(input logic [63:0] bits, input logic [3:0] ty);
        mtnc_op_t   o;
        logic [63:0] ext;
        logic        neg;
        logic [7:0]  e8;
        logic [10:0] e11;
        o   = '0;
        ext = '0;
        neg = 1'b0;
        e8  = bits[30:23];
        e11 = bits[62:52];
        unique case (ty)
            TY_I8:  begin ext = {{56{bits[7]}}, bits[7:0]};   neg = bits[7];  end
            TY_U8:  ext = {56'd0, bits[7:0]};
            TY_I16: begin ext = {{48{bits[15]}}, bits[15:0]}; neg = bits[15]; end
            TY_U16: ext = {48'd0, bits[15:0]};
            TY_I32: begin ext = {{32{bits[31]}}, bits[31:0]}; neg = bits[31]; end
            TY_U32: ext = {32'd0, bits[31:0]};
            TY_I64: begin ext = bits; neg = bits[63]; end
            TY_U64: ext = bits;
            default: ;
        endcase
        if (ty == TY_SGL) begin
            o.sign = bits[31];
            // quiet NaN, payload moved up to the top of the double fraction
            o.pat  = {bits[31], 11'h7FF, 1'b1, bits[21:0], 29'd0};
            if (e8 == 8'hFF) begin
                o.nan = (bits[22:0] != 23'd0);
                o.inf = (bits[22:0] == 23'd0);
            end else if (e8 == 8'd0) begin
                o.mag  = {41'd0, bits[22:0]};
                o.off  = -13'sd149;
                o.zero = (bits[22:0] == 23'd0);
            end else begin
                o.mag = {40'd0, 1'b1, bits[22:0]};
                o.off = $signed({5'd0, e8}) - 13'sd150;
            end
        end else if (ty == TY_DBL) begin
            o.sign = bits[63];
            o.pat  = bits;
            if (e11 == 11'h7FF) begin
                o.nan = (bits[51:0] != 52'd0);
                o.inf = (bits[51:0] == 52'd0);
            end else if (e11 == 11'd0) begin
                o.mag  = {12'd0, bits[51:0]};
                o.off  = -13'sd1074;
                o.zero = (bits[51:0] == 52'd0);
            end else begin
                o.mag = {11'd0, 1'b1, bits[51:0]};
                o.off = $signed({2'd0, e11}) - 13'sd1075;
            end
        end else begin
            o.sign = neg;
            o.mag  = neg ? (~ext + 64'd1) : ext;
            o.zero = (ext == 64'd0);
        end
        return o;
    endfunction

    // Leading zero count; the highest set bit wins
    function automatic logic [5:0] lzc(input logic [63:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) n = 6'(63 - i);
        end
        return n;
    endfunction

    // Normalize: leading one to bit 63, exponent of that bit
    function automatic mtnc_op_t norm(input mtnc_op_t o, input logic [5:0] lz);
        mtnc_op_t r;
        r = o;
        if (o.inf) begin
            r.mag = {1'b1, 63'd0};
            r.off = INF_EXP;
        end else begin
            r.mag = o.mag << lz;
            r.off = o.off + 13'sd63 - $signed({7'd0, lz});
        end
        return r;
    endfunction

    // Round a normalized 64-bit integer to 53 bits, ties to even
    function automatic mtnc_op_t rnd(input mtnc_op_t o);
        mtnc_op_t    r;
        logic        up;
        logic [53:0] sum;
        r   = o;
        up  = o.mag[10] && ((|o.mag[9:0]) || o.mag[11]);
        sum = {1'b0, o.mag[63:11]} + {53'd0, up};
        if (sum[53]) begin
            r.mag = {1'b1, 63'd0};
            r.off = o.off + 13'sd1;
        end else begin
            r.mag = {sum[52:0], 11'd0};
        end
        return r;
    endfunction

    // Pipeline registers
    logic [3:0] vld_reg;
    logic       out_vld_reg;
    logic [1:0] res_reg;
    mtnc_op_t   a1_reg, b1_reg, a2_reg, b2_reg, a3_reg, b3_reg, a4_reg, b4_reg;
    logic [5:0] lza2_reg, lzb2_reg;
    mtnc_ctl_t  c1_reg, c2_reg, c3_reg, c4_reg;
    logic       en;

    // Input field decode
    logic [3:0] a_type, b_type;
    logic       diff, special, both_f;
    mtnc_ctl_t  c1_next;

    assign a_type = s_tdata[67:64];
    assign b_type = s_tdata[135:132];
    assign diff   = (a_type != b_type);
    assign special = diff
        && (a_type == TY_I64 || a_type == TY_U64 || a_type == TY_DBL)
        && (b_type == TY_I64 || b_type == TY_U64 || b_type == TY_DBL);
    assign both_f = (a_type == TY_SGL || a_type == TY_DBL)
                 && (b_type == TY_SGL || b_type == TY_DBL);

    always_comb begin
        c1_next.invalid    = (a_type > TY_DBL) || (b_type > TY_DBL);
        c1_next.both_float = both_f;
        c1_next.nan_mode   = s_tdata[136];
        c1_next.rnd_a      = diff && !special && (a_type == TY_I64 || a_type == TY_U64);
        c1_next.rnd_b      = diff && !special && (b_type == TY_I64 || b_type == TY_U64);
    end

    // Stall the whole pipe only when the output beat is held
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[2:0], s_tvalid};
            out_vld_reg <= vld_reg[3];
        end
    end

    // Compare stage logic on rounded operands
    logic a_neg, b_neg, mag_lt, mag_eq, any_nan, lt_c, eq_c;
    always_comb begin
        a_neg   = a4_reg.sign && !a4_reg.zero;
        b_neg   = b4_reg.sign && !b4_reg.zero;
        any_nan = a4_reg.nan || b4_reg.nan;
        if (a4_reg.zero || b4_reg.zero) begin
            mag_lt = a4_reg.zero && !b4_reg.zero;
            mag_eq = a4_reg.zero && b4_reg.zero;
        end else begin
            mag_lt = (a4_reg.off < b4_reg.off)
                  || (a4_reg.off == b4_reg.off && a4_reg.mag < b4_reg.mag);
            mag_eq = (a4_reg.off == b4_reg.off) && (a4_reg.mag == b4_reg.mag);
        end
        if (a_neg != b_neg) lt_c = a_neg;
        else if (a_neg)     lt_c = !mag_lt && !mag_eq;
        else                lt_c = mag_lt;
        eq_c = (a_neg == b_neg) && mag_eq;
        if (any_nan) begin
            lt_c = 1'b0;
            eq_c = 1'b0;
        end
        // Bit-pattern equality: NaNs by pattern, signed zeros distinct
        if (c4_reg.nan_mode && c4_reg.both_float) begin
            if (any_nan) eq_c = a4_reg.nan && b4_reg.nan && (a4_reg.pat == b4_reg.pat);
            else         eq_c = mag_eq && (a4_reg.sign == b4_reg.sign);
        end
        if (c4_reg.invalid) begin
            lt_c = 1'b0;
            eq_c = 1'b0;
        end
    end

    // Data path stages
    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= decode(s_tdata[63:0], a_type);
            b1_reg   <= decode(s_tdata[131:68], b_type);
            c1_reg   <= c1_next;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            lza2_reg <= lzc(a1_reg.mag);
            lzb2_reg <= lzc(b1_reg.mag);
            c2_reg   <= c1_reg;
            a3_reg   <= norm(a2_reg, lza2_reg);
            b3_reg   <= norm(b2_reg, lzb2_reg);
            c3_reg   <= c2_reg;
            a4_reg   <= c3_reg.rnd_a ? rnd(a3_reg) : a3_reg;
            b4_reg   <= c3_reg.rnd_b ? rnd(b3_reg) : b3_reg;
            c4_reg   <= c3_reg;
            res_reg  <= {eq_c, lt_c};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, res_reg};

endmodule

/* sv/mtnc_checker.sv */
// Port-level checker for the mixed-type number compare unit, with its bind.
module mtnc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata
);

    // Held result beat keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Less-than and equal never both set
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("less_than and equal_flag both set");

    // Fill bits stay zero
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:2] == 6'd0)
        else $error("fill bits of result nonzero");

    // Empty pipe after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind mixed_type_number_compare_unit mtnc_checker u_mtnc_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for the mixed-type number compare unit.
`timescale 1ns / 1ps

module tb_top
    import mtnc_pkg::*;
;

    // packed so that a_bits lands in the lowest bits of tdata
    typedef struct packed {
        logic        nan_mode;
        logic [3:0]  b_type;
        logic [63:0] b_bits;
        logic [3:0]  a_type;
        logic [63:0] a_bits;
    } cmp_req_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_flags_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // a_bits, a_type, b_bits, b_type, nan_equal_mode, zero fill
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // less_than, equal_flag, zero fill
    logic [7:0]   m_tdata;

    cmp_req_t   pending_reqs[$];
    cmp_flags_t expected_flags[$];
    int         n_errors = 0;
    int         n_results = 0;
    bit         quiet = 1'b0;
    bit         held_once = 1'b0;
    int         s_gap = 0;
    int         m_gap = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;

    mixed_type_number_compare_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    // integer value of an integer type, widened to 66 bits
    function automatic logic signed [65:0] int_value(logic [63:0] x, logic [3:0] t);
        int                 w;
        logic [63:0]        m;
        logic signed [65:0] r;
        w = 8 << t[2:1];
        m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        r = {2'b00, x & m};
        if (!t[0] && x[w-1])
            r = r - (66'sd1 <<< w);
        return r;
    endfunction

    // integer rounded to nearest-even double
    function automatic logic [63:0] int_to_dbl(logic signed [65:0] v);
        logic        sgn;
        logic [65:0] mag;
        logic [65:0] keep;
        logic [65:0] rem;
        logic [65:0] half;
        int          p;
        int          sh;
        sgn = v < 0;
        mag = sgn ? -v : v;
        if (mag == 0)
            return 64'd0;
        p = 0;
        for (int i = 0; i < 66; i++)
            if (mag[i]) p = i;
        if (p <= 52) begin
            keep = mag << (52 - p);
        end else begin
            sh = p - 52;
            keep = mag >> sh;
            rem = mag & ((66'd1 << sh) - 66'd1);
            half = 66'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0]))
                keep = keep + 66'd1;
            if (keep[53]) begin
                keep = keep >> 1;
                p++;
            end
        end
        return {sgn, 11'(p + 1023), keep[51:0]};
    endfunction

    // exact single to double widening; NaNs become quiet, payload kept
    function automatic logic [63:0] sgl_to_dbl(logic [31:0] u);
        logic [22:0] f;
        int          k;
        f = u[22:0];
        if (u[30:23] == 8'hFF) begin
            if (f != 0)
                return {u[31], 11'h7FF, 1'b1, 22'(f) << 0, 29'd0} |
                       ({12'd0, 52'(f)} << 29);
            return {u[31], 11'h7FF, 52'd0};
        end
        if (u[30:23] != 0)
            return {u[31], 11'(u[30:23] - 127 + 1023), f, 29'd0};
        if (f == 0)
            return {u[31], 63'd0};
        k = 0;
        for (int i = 0; i < 23; i++)
            if (f[i]) k = i;
        return {u[31], 11'(k - 149 + 1023), 52'({29'd0, f} << (52 - k))};
    endfunction

    // exact integer value of a double known to be integral and below 2^65
    function automatic logic signed [65:0] dbl_int_value(logic [63:0] d);
        logic signed [65:0] v;
        int                 ex;
        if (d[62:52] == 0)
            return 66'sd0;
        ex = int'(d[62:52]) - 1075;
        v = {13'd0, 1'b1, d[51:0]};
        v = (ex >= 0) ? (v <<< ex) : (v >>> -ex);
        return d[63] ? -v : v;
    endfunction

    function automatic logic [63:0] dbl_pattern(logic [63:0] x, logic [3:0] t);
        if (t == TY_DBL) return x;
        if (t == TY_SGL) return sgl_to_dbl(x[31:0]);
        return int_to_dbl(int_value(x, t));
    endfunction

    function automatic bit exact_pair(logic [3:0] ta, logic [3:0] tb);
        return ta != tb && (ta == TY_I64 || ta == TY_U64 || ta == TY_DBL) &&
               (tb == TY_I64 || tb == TY_U64 || tb == TY_DBL);
    endfunction

    function automatic cmp_flags_t compare_pair(cmp_req_t q);
        cmp_flags_t         r;
        logic [63:0]        pa;
        logic [63:0]        pb;
        real                ra;
        real                rb;
        logic signed [65:0] ia;
        logic signed [65:0] ib;
        r = '0;
        if (q.a_type > TY_DBL || q.b_type > TY_DBL)
            return r;
        pa = dbl_pattern(q.a_bits, q.a_type);
        pb = dbl_pattern(q.b_bits, q.b_type);
        ra = $bitstoreal(pa);
        rb = $bitstoreal(pb);
        // both floating: plain double compare, pattern equality in NaN mode
        if (q.a_type >= TY_SGL && q.b_type >= TY_SGL) begin
            r.lt = ra < rb;
            r.eq = q.nan_mode ? (pa == pb) : (ra == rb);
            return r;
        end
        // same integer type: native compare
        if (q.a_type == q.b_type) begin
            ia = int_value(q.a_bits, q.a_type);
            ib = int_value(q.b_bits, q.b_type);
            r.lt = ia < ib;
            r.eq = ia == ib;
            return r;
        end
        if (ra < rb) begin
            r.lt = 1'b1;
            return r;
        end
        if (rb < ra || ra != rb)
            return r;
        r.eq = 1'b1;
        // doubles tie: settle 64-bit pairs by their exact integer values
        if (exact_pair(q.a_type, q.b_type)) begin
            ia = (q.a_type == TY_DBL) ? dbl_int_value(q.a_bits) : int_value(q.a_bits, q.a_type);
            ib = (q.b_type == TY_DBL) ? dbl_int_value(q.b_bits) : int_value(q.b_bits, q.b_type);
            r.lt = ia < ib;
            r.eq = ia == ib;
        end
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] special_value(logic [3:0] t);
        logic [63:0] v;
        v = rand64();
        if (t == TY_DBL) begin
            case ($urandom_range(0, 9))
                0: v = 64'h0000_0000_0000_0000;
                1: v = 64'h8000_0000_0000_0000;
                2: v = 64'h7FF0_0000_0000_0000;
                3: v = 64'hFFF0_0000_0000_0000;
                4: v = {v[63], 11'h7FF, v[51:0] | 52'd1};
                5: v = 64'h43E0_0000_0000_0000;
                6: v = 64'hC3E0_0000_0000_0000;
                7: v = 64'h43F0_0000_0000_0000;
                8: v = {v[63], 11'd0, v[51:0]};
                default: v = {v[63], 11'(1023 + $urandom_range(0, 66)), v[51:0]};
            endcase
        end else if (t == TY_SGL) begin
            case ($urandom_range(0, 7))
                0: v[31:0] = 32'h0000_0000;
                1: v[31:0] = 32'h8000_0000;
                2: v[31:0] = {v[31], 8'hFF, 23'd0};
                3: v[31:0] = {v[31], 8'hFF, v[22:0] | 23'd1};
                4: v[31:0] = {v[31], 8'd0, v[22:0]};
                5: v[31:0] = {v[31], 8'(127 + $urandom_range(0, 64)), v[22:0]};
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = '1;
                2: v = {v[63:8], 8'h80} << ((8 << t[2:1]) - 8);
                3: v = ~(64'd1 << ((8 << t[2:1]) - 1));
                4: v = v >> $urandom_range(0, 63);
                default: ;
            endcase
        end
        return v;
    endfunction

    // a pair whose doubles likely tie, to reach the exact tie break
    function automatic cmp_req_t near_tie();
        cmp_req_t           q;
        logic [3:0]         tys[3];
        logic signed [65:0] v;
        int                 d;
        tys = '{TY_I64, TY_U64, TY_DBL};
        q.a_type = tys[$urandom_range(0, 2)];
        do q.b_type = tys[$urandom_range(0, 2)]; while (q.b_type == q.a_type);
        if (q.a_type == TY_DBL) q.a_type = (q.b_type == TY_I64) ? TY_U64 : TY_I64;
        q.a_bits = rand64();
        if ($urandom_range(0, 2) == 0) q.a_bits = q.a_bits >> $urandom_range(1, 12);
        v = int_value(q.a_bits, q.a_type);
        d = int'($urandom_range(0, 4)) - 2;
        if (q.b_type == TY_DBL)
            q.b_bits = int_to_dbl(v) + 64'(d);
        else
            q.b_bits = 64'(v + d);
        q.nan_mode = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) begin
            {q.a_bits, q.b_bits} = {q.b_bits, q.a_bits};
            {q.a_type, q.b_type} = {q.b_type, q.a_type};
        end
        return q;
    endfunction

    function automatic cmp_req_t random_req();
        cmp_req_t q;
        if ($urandom_range(0, 3) == 0)
            return near_tie();
        q.a_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) :
                                                 4'($urandom_range(0, 9));
        q.b_type = ($urandom_range(0, 2) == 0) ? q.a_type :
                   ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) :
                                                 4'($urandom_range(0, 9));
        q.a_bits = $urandom_range(0, 1) ? special_value(q.a_type) : rand64();
        q.b_bits = $urandom_range(0, 1) ? special_value(q.b_type) : rand64();
        if ($urandom_range(0, 4) == 0) q.b_bits = q.a_bits;
        q.nan_mode = $urandom_range(0, 1);
        return q;
    endfunction

    function automatic cmp_req_t mk(logic [63:0] a, logic [3:0] ta, logic [63:0] b,
                                    logic [3:0] tb, logic nm);
        cmp_req_t q;
        q.a_bits = a;
        q.a_type = ta;
        q.b_bits = b;
        q.b_type = tb;
        q.nan_mode = nm;
        return q;
    endfunction

    // ---------------- sender ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_flags.push_back(compare_pair(cmp_req_t'(s_tdata[136:0])));
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_tdata <= {7'd0, pending_reqs.pop_front()};
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 19) == 0)
                        s_gap <= $urandom_range(1, 14);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver and checker ----------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_flags.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    n_errors++;
                end else begin
                    cmp_flags_t e;
                    e = expected_flags.pop_front();
                    if (m_tdata[0] !== e.lt) begin
                        $display("%0t: less_than expected %b actual %b",
                                 $time, e.lt, m_tdata[0]);
                        n_errors++;
                    end
                    if (m_tdata[1] !== e.eq) begin
                        $display("%0t: equal_flag expected %b actual %b",
                                 $time, e.eq, m_tdata[1]);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the pipeline fills and stalls its input
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (!held_once && n_results >= 300) begin
                held_once <= 1'b1;
                hold_left <= 300;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 14) == 0)
                    m_gap <= $urandom_range(1, 14);
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_flags.size() > 0)
            @(posedge aclk);
    endtask

    // ---------------- test sequence ----------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, NaN handling, signed zeros, ties, bad codes
        pending_reqs.push_back(mk('0, TY_I8, 64'hFF, TY_I8, 1'b0));
        pending_reqs.push_back(mk(64'hFFFF_FFFF_FFFF_FF7F, TY_I8, 64'h80, TY_U8, 1'b0));
        pending_reqs.push_back(mk(64'h8000, TY_I16, 64'h7FFF, TY_I16, 1'b0));
        pending_reqs.push_back(mk(64'hFFFF, TY_U16, 64'hFFFF_FFFF, TY_I32, 1'b0));
        pending_reqs.push_back(mk(64'h8000_0000, TY_U32, 64'h8000_0000, TY_I32, 1'b0));
        pending_reqs.push_back(mk('1, TY_U64, '1, TY_I64, 1'b0));
        pending_reqs.push_back(mk(64'h8000_0000_0000_0000, TY_I64, 64'h7FFF_FFFF_FFFF_FFFF,
                                  TY_U64, 1'b0));
        pending_reqs.push_back(mk('1, TY_U64, 64'h43F0_0000_0000_0000, TY_DBL, 1'b0));
        pending_reqs.push_back(mk(64'h7FFF_FFFF_FFFF_FFFF, TY_I64, 64'h43E0_0000_0000_0000,
                                  TY_DBL, 1'b0));
        pending_reqs.push_back(mk(64'hC3E0_0000_0000_0000, TY_DBL, 64'h8000_0000_0000_0000,
                                  TY_I64, 1'b0));
        pending_reqs.push_back(mk(64'h7FF8_0000_0000_0000, TY_DBL, 64'h7FF8_0000_0000_0000,
                                  TY_DBL, 1'b0));
        pending_reqs.push_back(mk(64'h7FF8_0000_0000_0000, TY_DBL, 64'h7FF8_0000_0000_0000,
                                  TY_DBL, 1'b1));
        pending_reqs.push_back(mk(64'h7FC0_0001, TY_SGL, 64'h7FF8_0000_2000_0000, TY_DBL, 1'b1));
        pending_reqs.push_back(mk(64'hFF80_0001, TY_SGL, 64'hFFF8_0000_2000_0000, TY_DBL, 1'b1));
        pending_reqs.push_back(mk(64'h8000_0000, TY_SGL, 64'h0, TY_DBL, 1'b0));
        pending_reqs.push_back(mk(64'h8000_0000, TY_SGL, 64'h0, TY_DBL, 1'b1));
        pending_reqs.push_back(mk(64'h7FC0_0000, TY_SGL, 64'd5, TY_I32, 1'b1));
        pending_reqs.push_back(mk(64'h0000_0001, TY_SGL, 64'h7F80_0000, TY_SGL, 1'b0));
        pending_reqs.push_back(mk(64'hABCD_0000_0000_0001, TY_U8, 64'h3FF0_0000_0000_0000,
                                  TY_DBL, 1'b0));
        pending_reqs.push_back(mk(64'd16777217, TY_I32, 64'h4B80_0000, TY_SGL, 1'b0));
        pending_reqs.push_back(mk(64'd1, TY_I16, 64'd1, 4'd10, 1'b0));
        pending_reqs.push_back(mk(64'd1, 4'd15, 64'd1, TY_U8, 1'b1));
        pending_reqs.push_back(mk(64'd3, 4'd12, 64'd3, 4'd12, 1'b0));
        wait_drained();

        // random body; the sender pauses between phases until all is back
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 3) quiet = 1'b1;
            for (int i = 0; i < 410; i++)
                pending_reqs.push_back(random_req());
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* files.f */
sv/mtnc_pkg.sv
sv/mixed_type_number_compare_unit.sv
sv/mtnc_checker.sv
test/tb_top.sv
